### rtl/core/tpl_pkg.sv
package tpl_pkg;

   localparam int TablePoints = 8;
   localparam int NumRegs = 8;
   localparam int RegIndexWidth = 3;
   localparam int RegWidth = 24;
   localparam int ResWidth = 16;
   localparam int TempWidth = 8;
   localparam int OutTempWidth = 10;
   localparam int RegionWidth = 2;

   localparam int Scale = 10000;
   localparam int ScaleWidth = 14;
   localparam int SlopeNumWidth = TempWidth + ScaleWidth;
   localparam int ProdWidth = SlopeNumWidth + ResWidth;
   localparam int ScaleQuoWidth = 25;
   localparam int SumWidth = 27;

   // division by the scale: a shift by four, then a reciprocal of 625
   localparam int ScaleShift = 4;
   localparam int ShiftedWidth = ProdWidth - ScaleShift;
   localparam int SplitWidth = 17;
   localparam int RecipWidth = 35;
   localparam int RecipHiWidth = RecipWidth - SplitWidth;
   localparam int RecipShift = 44;
   localparam logic [RecipWidth-1:0] ScaleRecip = 35'd28147497672;
   localparam int HiProdWidth = SplitWidth + RecipHiWidth;
   localparam int LoProdWidth = 2 * SplitWidth;
   localparam int FullProdWidth = ShiftedWidth + RecipWidth;
   localparam int ScaleStages = 3;

   localparam logic [RegionWidth-1:0] RegionInside = 2'd0;
   localparam logic [RegionWidth-1:0] RegionCold = 2'd1;
   localparam logic [RegionWidth-1:0] RegionHot = 2'd2;

   localparam logic signed [OutTempWidth-1:0] ColdTemp = OutTempWidth'(-10);
   localparam logic signed [OutTempWidth-1:0] HotTemp = OutTempWidth'(200);
   localparam logic signed [OutTempWidth-1:0] OutMax = OutTempWidth'(511);
   localparam logic signed [OutTempWidth-1:0] OutMin = OutTempWidth'(-512);
   localparam logic signed [SumWidth-1:0] SumMax = SumWidth'(511);
   localparam logic signed [SumWidth-1:0] SumMin = SumWidth'(-512);

   localparam logic [RegWidth-1:0] ResetTable [NumRegs] = '{
      24'd96536, 24'd675360, 24'd1648400, 24'd2625740,
      24'd3935160, 24'd5244830, 24'd6554500, 24'd9830900
   };

   function automatic logic [TempWidth-1:0] bp_temp(input logic [RegWidth-1:0] bp);
      return bp[RegWidth-1:ResWidth];
   endfunction

   function automatic logic [ResWidth-1:0] bp_res(input logic [RegWidth-1:0] bp);
      return bp[ResWidth-1:0];
   endfunction

endpackage

### rtl/core/tpl_slope_div.sv
module tpl_slope_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [tpl_pkg::SlopeNumWidth-1:0] in_num,
   input  logic [tpl_pkg::ResWidth-1:0]      in_den,
   output logic                              out_valid,
   output logic [tpl_pkg::SlopeNumWidth-1:0] out_quo
);
   import tpl_pkg::*;

   // restoring divider, one quotient bit per stage
   logic                     valid_ff [SlopeNumWidth];
   logic [SlopeNumWidth-1:0] num_ff [SlopeNumWidth];
   logic [SlopeNumWidth-1:0] quo_ff [SlopeNumWidth];
   logic [ResWidth-1:0]      rem_ff [SlopeNumWidth];
   logic [ResWidth-1:0]      den_ff [SlopeNumWidth];

   for (genvar j = 0; j < SlopeNumWidth; j++) begin : g_stage
      logic                     src_valid;
      logic [SlopeNumWidth-1:0] src_num;
      logic [SlopeNumWidth-1:0] src_quo;
      logic [ResWidth-1:0]      src_rem;
      logic [ResWidth-1:0]      src_den;
      logic [ResWidth:0]        trial;
      logic [ResWidth:0]        diff;
      logic [ResWidth-1:0]      rem_in;
      logic [SlopeNumWidth-1:0] quo_in;
      logic [SlopeNumWidth-1:0] num_in;

      if (j == 0) begin : g_head
         assign src_valid = in_valid;
         assign src_num = in_num;
         assign src_quo = '0;
         assign src_rem = '0;
         assign src_den = in_den;
      end else begin : g_tail
         assign src_valid = valid_ff[j-1];
         assign src_num = num_ff[j-1];
         assign src_quo = quo_ff[j-1];
         assign src_rem = rem_ff[j-1];
         assign src_den = den_ff[j-1];
      end

      assign trial = {src_rem, src_num[SlopeNumWidth-1]};
      assign diff = trial - {1'b0, src_den};
      // no borrow means the trial remainder covers the divisor
      assign rem_in = diff[ResWidth] ? trial[ResWidth-1:0] : diff[ResWidth-1:0];
      assign quo_in = {src_quo[SlopeNumWidth-2:0], ~diff[ResWidth]};
      assign num_in = {src_num[SlopeNumWidth-2:0], 1'b0};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else begin
            valid_ff[j] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         num_ff[j] <= num_in;
         quo_ff[j] <= quo_in;
         rem_ff[j] <= rem_in;
         den_ff[j] <= src_den;
      end
   end

   assign out_valid = valid_ff[SlopeNumWidth-1];
   assign out_quo = quo_ff[SlopeNumWidth-1];

endmodule

### rtl/core/tpl_scale_div.sv
module tpl_scale_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [tpl_pkg::ProdWidth-1:0]     in_num,
   output logic                              out_valid,
   output logic [tpl_pkg::ScaleQuoWidth-1:0] out_quo
);
   import tpl_pkg::*;

   // divide by the fixed scale: shift out the factor of 16, multiply by a
   // rounded-up reciprocal of 625 and keep the top bits; exact below 2^34
   logic [ScaleStages-1:0]   valid_ff;
   logic [ShiftedWidth-1:0]  shifted;
   logic [SplitWidth-1:0]    n_hi, n_lo;
   logic [RecipHiWidth-1:0]  m_hi;
   logic [SplitWidth-1:0]    m_lo;
   logic [HiProdWidth-1:0]   hh_ff, lh_ff, hh_mid_ff;
   logic [LoProdWidth-1:0]   hl_ff, ll_ff, ll_mid_ff;
   logic [HiProdWidth:0]     cross_ff;
   logic [FullProdWidth-1:0] product;
   logic [ScaleQuoWidth-1:0] quo_ff;

   assign shifted = in_num[ProdWidth-1:ScaleShift];
   assign n_hi = shifted[ShiftedWidth-1:SplitWidth];
   assign n_lo = shifted[SplitWidth-1:0];
   assign m_hi = ScaleRecip[RecipWidth-1:SplitWidth];
   assign m_lo = ScaleRecip[SplitWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[ScaleStages-2:0], in_valid};
      end
   end

   // partial products of the two halves
   always_ff @(posedge clock) begin
      hh_ff <= HiProdWidth'(n_hi) * HiProdWidth'(m_hi);
      hl_ff <= LoProdWidth'(n_hi) * LoProdWidth'(m_lo);
      lh_ff <= HiProdWidth'(n_lo) * HiProdWidth'(m_hi);
      ll_ff <= LoProdWidth'(n_lo) * LoProdWidth'(m_lo);
   end

   always_ff @(posedge clock) begin
      cross_ff <= (HiProdWidth+1)'(hl_ff) + (HiProdWidth+1)'(lh_ff);
      hh_mid_ff <= hh_ff;
      ll_mid_ff <= ll_ff;
   end

   // high and low products do not overlap, so they join by concatenation
   assign product = {hh_mid_ff, ll_mid_ff}
                    + FullProdWidth'({cross_ff, {SplitWidth{1'b0}}});

   always_ff @(posedge clock) begin
      quo_ff <= product[FullProdWidth-1:RecipShift];
   end

   assign out_valid = valid_ff[ScaleStages-1];
   assign out_quo = quo_ff;

endmodule

### rtl/core/thermistor_piecewise_linear.sv
// Thermistor resistance to temperature by piecewise linear lookup.
// Input: a sample on req_resistance is taken at a rising edge where start is
// high and busy is low. busy is high only while reset is asserted, so one
// sample may be taken every cycle.
// Output: each sample gives exactly one result on rsp_temperature and
// rsp_region, marked by rsp_strobe for one cycle; results come out in the
// order the samples went in. The receiver cannot hold results off.
// Pipeline: between the accepting edge and the rsp_ ports lie the slope
// divider (22 bit-stages), the scale dividers (3 stages of reciprocal
// multiply) and five further register stages.
// Throughput: one sample per cycle.
// Breakpoint registers: written through the csr_ channel (ready whenever out
// of reset); index i selects breakpoint i. Writes are meant for an idle block.
// Reset: synchronous; clears the pipeline and reloads the default table.
module thermistor_piecewise_linear (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [tpl_pkg::ResWidth-1:0]             req_resistance,
   output logic                                     rsp_strobe,
   output logic signed [tpl_pkg::OutTempWidth-1:0]  rsp_temperature,
   output logic [tpl_pkg::RegionWidth-1:0]          rsp_region,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [tpl_pkg::RegIndexWidth-1:0]        csr_index,
   input  logic [tpl_pkg::RegWidth-1:0]             csr_data
);
   import tpl_pkg::*;

   typedef struct packed {
      logic [RegionWidth-1:0] region;
      logic [TempWidth-1:0]   t_lo;
      logic                   a_neg;
      logic [ResWidth-1:0]    r_hi;
      logic [ResWidth-1:0]    res;
   } slope_side_type;

   typedef struct packed {
      logic [RegionWidth-1:0] region;
      logic [TempWidth-1:0]   t_lo;
      logic                   a_neg;
   } fin_side_type;

   logic [RegWidth-1:0] bp_ff [NumRegs];

   logic                in_valid_ff;
   logic [ResWidth-1:0] in_res_ff;

   logic                   seg_valid_ff;
   logic [RegionWidth-1:0] seg_region_ff, seg_region_in;
   logic [TempWidth-1:0]   seg_t_lo_ff, seg_t_lo_in;
   logic [TempWidth-1:0]   seg_t_hi_ff, seg_t_hi_in;
   logic [ResWidth-1:0]    seg_r_hi_ff, seg_r_hi_in;
   logic [ResWidth-1:0]    seg_r_lo_ff, seg_r_lo_in;
   logic [ResWidth-1:0]    seg_res_ff;

   logic                     num_valid_ff;
   logic [SlopeNumWidth-1:0] num_ff, num_in;
   logic [ResWidth-1:0]      den_ff;
   slope_side_type           num_side_ff, num_side_in;
   logic [TempWidth-1:0]     dt_mag;

   logic                     slope_valid;
   logic [SlopeNumWidth-1:0] slope_quo;
   slope_side_type           slope_side_ff [SlopeNumWidth];
   slope_side_type           slope_side;

   logic                 prod_valid_ff;
   logic [ProdWidth-1:0] prod_res_ff;
   logic [ProdWidth-1:0] prod_hi_ff;
   fin_side_type         prod_side_ff;

   logic                     scale_res_valid, scale_hi_valid;
   logic [ScaleQuoWidth-1:0] scale_res_quo, scale_hi_quo;
   fin_side_type             fin_side_ff [ScaleStages];
   fin_side_type             fin_side;

   logic signed [SumWidth-1:0]     sum;
   logic signed [SumWidth-1:0]     t_ext, qr_ext, qh_ext;
   logic signed [OutTempWidth-1:0] temp_in;

   logic                           rsp_strobe_ff;
   logic signed [OutTempWidth-1:0] rsp_temp_ff;
   logic [RegionWidth-1:0]         rsp_region_ff;

   assign busy = reset;
   assign csr_ready = ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NumRegs; k++) begin
            bp_ff[k] <= ResetTable[k];
         end
      end else if (csr_valid && csr_ready) begin
         bp_ff[csr_index] <= csr_data;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         seg_valid_ff <= 1'b0;
         num_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
         seg_valid_ff <= in_valid_ff;
         num_valid_ff <= seg_valid_ff;
         prod_valid_ff <= slope_valid;
         rsp_strobe_ff <= scale_res_valid;
      end
   end

   // segment search, first matching segment wins
   always_comb begin
      logic found;
      found = 1'b0;
      seg_t_lo_in = bp_temp(bp_ff[0]);
      seg_t_hi_in = bp_temp(bp_ff[1]);
      seg_r_hi_in = bp_res(bp_ff[0]);
      seg_r_lo_in = bp_res(bp_ff[1]);
      for (int i = TablePoints - 2; i >= 0; i--) begin
         if (in_res_ff <= bp_res(bp_ff[i]) && in_res_ff > bp_res(bp_ff[i+1])) begin
            found = 1'b1;
            seg_t_lo_in = bp_temp(bp_ff[i]);
            seg_t_hi_in = bp_temp(bp_ff[i+1]);
            seg_r_hi_in = bp_res(bp_ff[i]);
            seg_r_lo_in = bp_res(bp_ff[i+1]);
         end
      end
      if (in_res_ff > bp_res(bp_ff[0])) begin
         seg_region_in = RegionCold;
      end else if (found) begin
         seg_region_in = RegionInside;
      end else begin
         seg_region_in = RegionHot;
      end
   end

   // slope numerator and side fields; the slope sign is the opposite of dT
   always_comb begin
      num_side_in.a_neg = seg_t_hi_ff > seg_t_lo_ff;
      dt_mag = num_side_in.a_neg ? seg_t_hi_ff - seg_t_lo_ff : seg_t_lo_ff - seg_t_hi_ff;
      num_in = SlopeNumWidth'(dt_mag) * SlopeNumWidth'(Scale);
      num_side_in.region = seg_region_ff;
      num_side_in.t_lo = seg_t_lo_ff;
      num_side_in.r_hi = seg_r_hi_ff;
      num_side_in.res = seg_res_ff;
   end

   always_ff @(posedge clock) begin
      in_res_ff <= req_resistance;
      seg_region_ff <= seg_region_in;
      seg_t_lo_ff <= seg_t_lo_in;
      seg_t_hi_ff <= seg_t_hi_in;
      seg_r_hi_ff <= seg_r_hi_in;
      seg_r_lo_ff <= seg_r_lo_in;
      seg_res_ff <= in_res_ff;
      num_ff <= num_in;
      den_ff <= seg_r_hi_ff - seg_r_lo_ff;
      num_side_ff <= num_side_in;
   end

   tpl_slope_div u_slope_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_valid_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .out_valid (slope_valid),
      .out_quo   (slope_quo)
   );

   always_ff @(posedge clock) begin
      slope_side_ff[0] <= num_side_ff;
      for (int k = 1; k < SlopeNumWidth; k++) begin
         slope_side_ff[k] <= slope_side_ff[k-1];
      end
   end

   assign slope_side = slope_side_ff[SlopeNumWidth-1];

   // magnitudes of r*A and A*R_i
   always_ff @(posedge clock) begin
      prod_res_ff <= ProdWidth'(slope_quo) * ProdWidth'(slope_side.res);
      prod_hi_ff <= ProdWidth'(slope_quo) * ProdWidth'(slope_side.r_hi);
      prod_side_ff.region <= slope_side.region;
      prod_side_ff.t_lo <= slope_side.t_lo;
      prod_side_ff.a_neg <= slope_side.a_neg;
   end

   tpl_scale_div u_scale_res (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid_ff),
      .in_num    (prod_res_ff),
      .out_valid (scale_res_valid),
      .out_quo   (scale_res_quo)
   );

   tpl_scale_div u_scale_hi (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid_ff),
      .in_num    (prod_hi_ff),
      .out_valid (scale_hi_valid),
      .out_quo   (scale_hi_quo)
   );

   always_ff @(posedge clock) begin
      fin_side_ff[0] <= prod_side_ff;
      for (int k = 1; k < ScaleStages; k++) begin
         fin_side_ff[k] <= fin_side_ff[k-1];
      end
   end

   assign fin_side = fin_side_ff[ScaleStages-1];

   // truncation toward zero: both quotients carry the sign of the slope
   always_comb begin
      t_ext = SumWidth'(fin_side.t_lo);
      qr_ext = SumWidth'(scale_res_quo);
      qh_ext = SumWidth'(scale_hi_quo);
      if (fin_side.a_neg) begin
         sum = t_ext + qh_ext - qr_ext;
      end else begin
         sum = t_ext - qh_ext + qr_ext;
      end
      if (fin_side.region == RegionCold) begin
         temp_in = ColdTemp;
      end else if (fin_side.region == RegionHot) begin
         temp_in = HotTemp;
      end else if (sum > SumMax) begin
         temp_in = OutMax;
      end else if (sum < SumMin) begin
         temp_in = OutMin;
      end else begin
         temp_in = sum[OutTempWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_temp_ff <= temp_in;
      rsp_region_ff <= fin_side.region;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_temperature = rsp_temp_ff;
   assign rsp_region = rsp_region_ff;

   a_scale_lockstep : assert property (@(posedge clock) disable iff (reset)
      scale_res_valid == scale_hi_valid)
      else $error("scale dividers out of step");

   a_segment_falls : assert property (@(posedge clock) disable iff (reset)
      seg_valid_ff && seg_region_ff == RegionInside |-> seg_r_hi_ff > seg_r_lo_ff)
      else $error("matched segment has no falling resistance");

   a_inside_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_region == RegionInside |->
         rsp_temperature >= -10'sd4 && rsp_temperature <= 10'sd259)
      else $error("interpolated temperature outside breakpoint range");

endmodule

### test/thermistor_piecewise_linear_tb.sv
module thermistor_piecewise_linear_tb;
   import tpl_pkg::*;

   typedef struct packed {
      logic signed [OutTempWidth-1:0] temperature;
      logic [RegionWidth-1:0]         zone;
   } reading_type;

   class reading_tracker;
      logic [RegWidth-1:0] breakpoint [NumRegs];
      reading_type         pending[$];
      int                  mismatches;

      function new();
         foreach (breakpoint[k]) breakpoint[k] = ResetTable[k];
         mismatches = 0;
      endfunction

      function void set_breakpoint(int k, logic [RegWidth-1:0] value);
         breakpoint[k] = value;
      endfunction

      function int outstanding();
         return pending.size();
      endfunction

      function longint deg_of(int k);
         return longint'(breakpoint[k][RegWidth-1:ResWidth]);
      endfunction

      function longint ohms_of(int k);
         return longint'(breakpoint[k][ResWidth-1:0]);
      endfunction

      // linear interpolation on the first segment that brackets the sample
      function reading_type predict_reading(logic [ResWidth-1:0] ohms);
         reading_type rd;
         longint      r, hi, lo, slope, offs, val;
         r = longint'(ohms);
         rd.temperature = HotTemp;
         rd.zone = RegionHot;
         if (r > ohms_of(0)) begin
            rd.temperature = ColdTemp;
            rd.zone = RegionCold;
            return rd;
         end
         for (int k = 0; k < TablePoints - 1; k++) begin
            hi = ohms_of(k);
            lo = ohms_of(k + 1);
            if (r <= hi && r > lo) begin
               slope = (deg_of(k + 1) - deg_of(k)) * Scale / (lo - hi);
               offs = deg_of(k) - slope * hi / Scale;
               val = r * slope / Scale + offs;
               if (val > longint'(OutMax)) val = longint'(OutMax);
               if (val < longint'(OutMin)) val = longint'(OutMin);
               rd.temperature = val[OutTempWidth-1:0];
               rd.zone = RegionInside;
               return rd;
            end
         end
         return rd;
      endfunction

      function void note_sample(logic [ResWidth-1:0] ohms);
         pending.push_back(predict_reading(ohms));
      endfunction

      function void check_reading(logic signed [OutTempWidth-1:0] temperature,
                                  logic [RegionWidth-1:0] zone);
         reading_type exp_rd;
         if (pending.size() == 0) begin
            $error("result with nothing outstanding: temperature %0d region %0d",
                   temperature, zone);
            mismatches++;
            return;
         end
         exp_rd = pending.pop_front();
         if (temperature !== exp_rd.temperature) begin
            $error("temperature: expected %0d, got %0d", exp_rd.temperature, temperature);
            mismatches++;
         end
         if (zone !== exp_rd.zone) begin
            $error("region: expected %0d, got %0d", exp_rd.zone, zone);
            mismatches++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [ResWidth-1:0]           req_resistance = '0;
   logic                          rsp_strobe;
   logic signed [OutTempWidth-1:0] rsp_temperature;
   logic [RegionWidth-1:0]        rsp_region;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [RegIndexWidth-1:0]      csr_index = '0;
   logic [RegWidth-1:0]           csr_data = '0;

   reading_tracker tracker;

   thermistor_piecewise_linear uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_resistance  (req_resistance),
      .rsp_strobe      (rsp_strobe),
      .rsp_temperature (rsp_temperature),
      .rsp_region      (rsp_region),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) tracker.check_reading(rsp_temperature, rsp_region);
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task send_sample(input logic [ResWidth-1:0] ohms);
      start = 1'b1;
      req_resistance = ohms;
      do @(posedge clock); while (busy);
      tracker.note_sample(ohms);
      @(negedge clock);
   endtask

   task pause(input int cycles);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task drain;
      start = 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task load_table(input logic [RegWidth-1:0] values [NumRegs]);
      for (int k = 0; k < NumRegs; k++) begin
         csr_valid = 1'b1;
         csr_index = RegIndexWidth'(k);
         csr_data = values[k];
         do @(posedge clock); while (!csr_ready);
         tracker.set_breakpoint(k, values[k]);
         @(negedge clock);
      end
      csr_valid = 1'b0;
   endtask

   // half uniform, half within a couple of ohms of a breakpoint
   function logic [ResWidth-1:0] pick_ohms();
      int base;
      if ($urandom_range(0, 1) == 0) return ResWidth'($urandom_range(0, 65535));
      base = int'(tracker.ohms_of($urandom_range(0, NumRegs - 1)))
             + int'($urandom_range(0, 4)) - 2;
      if (base < 0) base = 0;
      if (base > 65535) base = 65535;
      return ResWidth'(base);
   endfunction

   task run_samples(input int count);
      int left, burst, longest;
      left = count;
      longest = ($urandom_range(0, 3) == 0) ? 80 : 20;
      while (left > 0) begin
         burst = $urandom_range(1, longest);
         while (burst > 0 && left > 0) begin
            send_sample(pick_ohms());
            burst--;
            left--;
         end
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
      end
   endtask

   initial begin
      logic [RegWidth-1:0]  table_vals [NumRegs];
      logic [ResWidth-1:0]  res_sorted [NumRegs];
      logic [ResWidth-1:0]  directed [$];
      logic [ResWidth-1:0]  swap;

      tracker = new();
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // default table: cold side, every breakpoint, some neighbours and midpoints, hot side
      directed = '{16'd65535, 16'd31001, 16'd31000, 16'd30999, 16'd25000, 16'd20000,
                   16'd19999, 16'd12345, 16'd10000, 16'd4300, 16'd3000, 16'd1950,
                   16'd1500, 16'd901, 16'd900, 16'd501, 16'd500, 16'd499, 16'd0};
      foreach (directed[k]) send_sample(directed[k]);
      pause(3);
      run_samples(300);
      drain();

      // random table ordered by falling resistance
      for (int k = 0; k < NumRegs; k++) res_sorted[k] = ResWidth'($urandom_range(0, 65535));
      for (int a = 0; a < NumRegs; a++)
         for (int b = a + 1; b < NumRegs; b++)
            if (res_sorted[b] > res_sorted[a]) begin
               swap = res_sorted[a];
               res_sorted[a] = res_sorted[b];
               res_sorted[b] = swap;
            end
      for (int k = 0; k < NumRegs; k++)
         table_vals[k] = {8'($urandom_range(0, 255)), res_sorted[k]};
      load_table(table_vals);
      run_samples(300);
      drain();

      // steepest swings between the temperature extremes, full resistance span
      table_vals = '{{8'd255, 16'd65535}, {8'd0, 16'd50000}, {8'd255, 16'd40000},
                     {8'd0, 16'd30000}, {8'd255, 16'd20000}, {8'd0, 16'd10000},
                     {8'd255, 16'd1}, {8'd0, 16'd0}};
      load_table(table_vals);
      send_sample(16'd0);
      send_sample(16'd1);
      send_sample(16'd65535);
      run_samples(250);
      drain();

      // unordered table with repeated resistances
      for (int k = 0; k < NumRegs; k++) table_vals[k] = RegWidth'($urandom);
      table_vals[3][ResWidth-1:0] = table_vals[2][ResWidth-1:0];
      table_vals[6][ResWidth-1:0] = table_vals[5][ResWidth-1:0];
      load_table(table_vals);
      run_samples(300);
      drain();

      // every register at its maximum, then at zero
      foreach (table_vals[k]) table_vals[k] = '1;
      load_table(table_vals);
      send_sample(16'd65535);
      run_samples(100);
      drain();
      foreach (table_vals[k]) table_vals[k] = '0;
      load_table(table_vals);
      send_sample(16'd0);
      run_samples(100);
      drain();

      // back to the default table
      foreach (table_vals[k]) table_vals[k] = ResetTable[k];
      load_table(table_vals);
      run_samples(300);
      drain();

      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("thermistor_piecewise_linear_tb: clean");
      end else begin
         $display("thermistor_piecewise_linear_tb: errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("thermistor_piecewise_linear_tb: errors");
      $finish;
   end

endmodule
